### rtl/core/dd_odom_pkg.sv
package dd_odom_pkg;

	localparam int REG_W       = 16;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_RADIUS     = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_SEPARATION = 1'b1;

	localparam logic [REG_W-1:0] RADIUS_RST     = 16'd4096;
	localparam logic [REG_W-1:0] SEPARATION_RST = 16'd14418;

	localparam int WHEEL_W = 16;
	localparam int TIME_W  = 16;
	localparam int POS_W   = 32;
	localparam int ANGLE_W = 16;
	localparam int RATE_W  = 32;

	localparam int TRIG_TABLE_BITS_DEF = 10;

	localparam int CORDIC_STEPS = 14;
	localparam int CSTEP_W      = 4;
	localparam int CORDIC_W     = 32;
	localparam int CORDIC_Z_W   = 18;
	localparam int ATAN_W       = 14;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic [ATAN_W-1:0] ATAN_BAM [CORDIC_STEPS] = '{
		14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
		14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
	};

	localparam int RAD_TO_BAM_W = 30;
	localparam logic [RAD_TO_BAM_W-1:0] RAD_TO_BAM = 30'd683565276;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPEED,
		ST_DIV,
		ST_STEP,
		ST_TURN,
		ST_HOLD
	} state_t;

endpackage

### rtl/core/dd_odom_req_if.sv
interface dd_odom_req_if;
	logic valid;
	logic ready;
	logic signed [dd_odom_pkg::WHEEL_W-1:0] left_wheel_speed;
	logic signed [dd_odom_pkg::WHEEL_W-1:0] right_wheel_speed;
	logic [dd_odom_pkg::TIME_W-1:0] elapsed_time;

	modport source (
		output valid,
		output left_wheel_speed,
		output right_wheel_speed,
		output elapsed_time,
		input  ready
	);

	modport sink (
		input  valid,
		input  left_wheel_speed,
		input  right_wheel_speed,
		input  elapsed_time,
		output ready
	);
endinterface

### rtl/core/dd_odom_rsp_if.sv
interface dd_odom_rsp_if;
	logic valid;
	logic ready;
	logic signed [dd_odom_pkg::POS_W-1:0] position_x;
	logic signed [dd_odom_pkg::POS_W-1:0] position_y;
	logic [dd_odom_pkg::ANGLE_W-1:0] heading_angle;
	logic signed [dd_odom_pkg::RATE_W-1:0] linear_speed;
	logic signed [dd_odom_pkg::RATE_W-1:0] yaw_rate;

	modport source (
		output valid,
		output position_x,
		output position_y,
		output heading_angle,
		output linear_speed,
		output yaw_rate,
		input  ready
	);

	modport sink (
		input  valid,
		input  position_x,
		input  position_y,
		input  heading_angle,
		input  linear_speed,
		input  yaw_rate,
		output ready
	);
endinterface

### rtl/core/dd_odom_smul.sv
module dd_odom_smul #(
	parameter int AW       = 16,
	parameter int BW       = 16,
	parameter int PW       = 32,
	parameter bit B_SIGNED = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic                 done,
	output logic signed [PW-1:0] p
);

	localparam int CW = $clog2(BW);

	logic [PW-1:0] mcand_q;
	logic [BW-1:0] mplier_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          last;
	logic [PW-1:0] addend;

	always_comb begin
		last = (cnt_q == CW'(BW - 1));
		addend = mplier_q[0] ? mcand_q : '0;
		if (B_SIGNED && last) begin
			addend = '0 - addend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + addend;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

### rtl/core/dd_odom_sdiv.sv
module dd_odom_sdiv #(
	parameter int NW = 40,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW+1:0] trial;
	logic          fit;

	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		fit     = !trial[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? trial[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/differential_drive_odometry_core.sv
// Dead-reckoning odometry for a differential-drive base.
// Requests arrive on req (valid/ready): left and right wheel speeds and the time
// since the previous sample. Each request yields one response on rsp with the
// updated pose (x, y, heading) and the forward speed and yaw rate it produced.
// Configuration (wheel radius, wheel separation) is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while no request is in
// flight, as the core itself does not enforce this. Each request passes in
// turn through a chain of bit-serial units: the 16-step speed multiply, the
// 40-step yaw-rate divider, the 16-step time multiply and the 30-step
// angle-conversion multiply. The 14-step heading rotation runs beside the
// speed multiply. The core takes no new request until the previous is done.
// A finished response sits in an output register; the next request is taken
// while it waits. If rsp is still stalled when the following response is done,
// the core holds it and keeps req.ready low until the register frees.
// Reset clears the pose to zero, loads the default radius and separation and
// empties the output register.
module differential_drive_odometry_core #(
	parameter int TRIG_TABLE_BITS = dd_odom_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dd_odom_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dd_odom_pkg::REG_W-1:0]         cfg_data,
	dd_odom_req_if.sink                           req,
	dd_odom_rsp_if.source                         rsp
);

	localparam int WW     = dd_odom_pkg::WHEEL_W;
	localparam int TW     = dd_odom_pkg::TIME_W;
	localparam int RW     = dd_odom_pkg::REG_W;
	localparam int XW     = dd_odom_pkg::POS_W;
	localparam int HW     = dd_odom_pkg::ANGLE_W;
	localparam int YW     = dd_odom_pkg::RATE_W;
	localparam int CRW    = dd_odom_pkg::CORDIC_W;
	localparam int ZW     = dd_odom_pkg::CORDIC_Z_W;
	localparam int SW     = dd_odom_pkg::CSTEP_W;
	localparam int SUM_W  = WW + 1;
	localparam int SPD_W  = SUM_W + RW + 1;
	localparam int V_LSB  = 9;
	localparam int V_W    = 24;
	localparam int VC_W   = CRW + V_W;
	localparam int VCS_W  = 26;
	localparam int DX_W   = VCS_W + TW;
	localparam int YD_W   = YW + TW;
	localparam int NUM_W  = 40;
	localparam int MAG_W  = 32;
	localparam int DROP   = HW - TRIG_TABLE_BITS;
	localparam logic [HW-1:0] TRIG_MASK = ~HW'((1 << DROP) - 1);
	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(16384);
	localparam logic signed [ZW-1:0] Z_HALF    = ZW'(32768);

	dd_odom_pkg::state_t state_q, state_d;

	logic [RW-1:0] radius_q;
	logic [RW-1:0] separation_q;
	logic [TW-1:0] dt_q;
	logic signed [XW-1:0] pose_x_q;
	logic signed [XW-1:0] pose_y_q;
	logic [HW-1:0] pose_heading_q;
	logic signed [YW-1:0] yaw_q;

	logic req_ready;
	logic start_speed;
	logic start_div;
	logic start_step;
	logic start_turn;
	logic pose_we;
	logic head_we;
	logic rsp_load;

	logic rsp_valid_q;
	logic signed [XW-1:0] out_x_q;
	logic signed [XW-1:0] out_y_q;
	logic [HW-1:0] out_heading_q;
	logic signed [YW-1:0] out_speed_q;
	logic signed [YW-1:0] out_yaw_q;

	logic signed [SUM_W-1:0] wheel_sum;
	logic signed [SUM_W-1:0] wheel_diff;
	logic signed [SPD_W-1:0] v_prod;
	logic signed [SPD_W-1:0] p_prod;
	logic v_done;
	logic signed [V_W-1:0] v_val;

	logic p_neg;
	logic [SPD_W-1:0] p_abs;
	logic [MAG_W-1:0] mag;
	logic [NUM_W-1:0] div_quo;
	logic div_done;
	logic sep_zero;
	logic [NUM_W-1:0] q_fit;
	logic yaw_sat;
	logic signed [YW-1:0] yaw_val;

	logic signed [CRW-1:0] cx_q;
	logic signed [CRW-1:0] cy_q;
	logic signed [ZW-1:0] cz_q;
	logic flip_q;
	logic [SW-1:0] cstep_q;
	logic cbusy_q;
	logic [HW-1:0] h_masked;
	logic signed [ZW-1:0] z_init;
	logic signed [ZW-1:0] z_fold;
	logic fold;
	logic signed [CRW-1:0] sx;
	logic signed [CRW-1:0] sy;
	logic signed [ZW-1:0] atan_step;
	logic signed [CRW-1:0] cos_val;
	logic signed [CRW-1:0] sin_val;

	logic signed [VC_W-1:0] vc_prod;
	logic signed [VC_W-1:0] vs_prod;
	logic signed [DX_W-1:0] dx_prod;
	logic signed [DX_W-1:0] dy_prod;
	logic signed [YD_W-1:0] yd_prod;
	logic yd_done;
	logic signed [YD_W-1:0] bam_prod;
	logic bam_done;
	logic [HW-1:0] bam;

	function automatic logic signed [XW-1:0] sat_add(
		input logic signed [XW-1:0] pos,
		input logic signed [VCS_W-1:0] step
	);
		logic signed [XW:0] sum;
		sum = (XW+1)'(pos) + (XW+1)'(step);
		if (sum[XW] != sum[XW-1]) begin
			sat_add = sum[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
		end else begin
			sat_add = sum[XW-1:0];
		end
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= dd_odom_pkg::RADIUS_RST;
			separation_q <= dd_odom_pkg::SEPARATION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dd_odom_pkg::REG_WHEEL_RADIUS:     radius_q     <= cfg_data;
				dd_odom_pkg::REG_WHEEL_SEPARATION: separation_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dd_odom_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dd_odom_pkg::ST_IDLE:  if (req.valid) state_d = dd_odom_pkg::ST_SPEED;
			dd_odom_pkg::ST_SPEED: if (v_done)    state_d = dd_odom_pkg::ST_DIV;
			dd_odom_pkg::ST_DIV:   if (div_done)  state_d = dd_odom_pkg::ST_STEP;
			dd_odom_pkg::ST_STEP:  if (yd_done)   state_d = dd_odom_pkg::ST_TURN;
			dd_odom_pkg::ST_TURN:  if (bam_done)  state_d = dd_odom_pkg::ST_HOLD;
			dd_odom_pkg::ST_HOLD: begin
				if (!rsp_valid_q || rsp.ready) state_d = dd_odom_pkg::ST_IDLE;
			end
			default: state_d = dd_odom_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		start_speed = 1'b0;
		start_div   = 1'b0;
		start_step  = 1'b0;
		start_turn  = 1'b0;
		pose_we     = 1'b0;
		head_we     = 1'b0;
		rsp_load    = 1'b0;
		case (state_q)
			dd_odom_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				start_speed = req.valid;
			end
			dd_odom_pkg::ST_SPEED: start_div = v_done;
			dd_odom_pkg::ST_DIV:   start_step = div_done;
			dd_odom_pkg::ST_STEP: begin
				start_turn = yd_done;
				pose_we    = yd_done;
			end
			dd_odom_pkg::ST_TURN:  head_we = bam_done;
			dd_odom_pkg::ST_HOLD:  rsp_load = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign req.ready = req_ready;

	always_ff @(posedge clk) begin
		if (start_speed) begin
			dt_q <= req.elapsed_time;
		end
		if (start_step) begin
			yaw_q <= yaw_val;
		end
	end

	// speed and raw turn product
	assign wheel_sum  = SUM_W'(req.right_wheel_speed) + SUM_W'(req.left_wheel_speed);
	assign wheel_diff = SUM_W'(req.right_wheel_speed) - SUM_W'(req.left_wheel_speed);

	dd_odom_smul #(.AW(SUM_W), .BW(RW), .PW(SPD_W), .B_SIGNED(1'b0)) u_mul_v (
		.clk(clk), .arst_n(arst_n), .start(start_speed),
		.a(wheel_sum), .b(radius_q), .done(v_done), .p(v_prod)
	);

	dd_odom_smul #(.AW(SUM_W), .BW(RW), .PW(SPD_W), .B_SIGNED(1'b0)) u_mul_p (
		.clk(clk), .arst_n(arst_n), .start(start_speed),
		.a(wheel_diff), .b(radius_q), .done(), .p(p_prod)
	);

	assign v_val = $signed(v_prod[V_LSB+V_W-1:V_LSB]);

	// yaw rate
	assign p_neg = p_prod[SPD_W-1];
	assign p_abs = p_neg ? (SPD_W'(0) - p_prod) : p_prod;
	assign mag   = p_abs[MAG_W-1:0];

	dd_odom_sdiv #(.NW(NUM_W), .DW(RW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(start_div),
		.num({mag, {(NUM_W-MAG_W){1'b0}}}), .den(separation_q),
		.done(div_done), .quo(div_quo)
	);

	always_comb begin
		sep_zero = (separation_q == '0);
		q_fit    = sep_zero ? '0 : div_quo;
		if (sep_zero) begin
			yaw_sat = (mag != '0);
		end else if (p_neg) begin
			yaw_sat = (q_fit > NUM_W'(40'h0080000000));
		end else begin
			yaw_sat = (q_fit > NUM_W'(40'h007FFFFFFF));
		end
		if (p_neg) begin
			yaw_val = yaw_sat ? {1'b1, {(YW-1){1'b0}}} : (YW'(0) - q_fit[YW-1:0]);
		end else begin
			yaw_val = yaw_sat ? {1'b0, {(YW-1){1'b1}}} : q_fit[YW-1:0];
		end
	end

	// heading rotation
	always_comb begin
		h_masked = pose_heading_q & TRIG_MASK;
		z_init   = ZW'($signed(h_masked));
		fold     = 1'b0;
		z_fold   = z_init;
		if (z_init > Z_QUARTER) begin
			z_fold = z_init - Z_HALF;
			fold   = 1'b1;
		end else if (z_init < -Z_QUARTER) begin
			z_fold = z_init + Z_HALF;
			fold   = 1'b1;
		end
		sx        = cx_q >>> cstep_q;
		sy        = cy_q >>> cstep_q;
		atan_step = $signed(ZW'(dd_odom_pkg::ATAN_BAM[cstep_q]));
		cos_val   = flip_q ? (CRW'(0) - cx_q) : cx_q;
		sin_val   = flip_q ? (CRW'(0) - cy_q) : cy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbusy_q <= 1'b0;
			cstep_q <= '0;
		end else if (start_speed) begin
			cbusy_q <= 1'b1;
			cstep_q <= '0;
		end else if (cbusy_q) begin
			cstep_q <= cstep_q + 1'b1;
			if (cstep_q == SW'(dd_odom_pkg::CORDIC_STEPS - 1)) begin
				cbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_speed) begin
			cx_q   <= dd_odom_pkg::CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= z_fold;
			flip_q <= fold;
		end else if (cbusy_q) begin
			if (!cz_q[ZW-1]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - atan_step;
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + atan_step;
			end
		end
	end

	// displacement
	dd_odom_smul #(.AW(CRW), .BW(V_W), .PW(VC_W), .B_SIGNED(1'b1)) u_mul_vc (
		.clk(clk), .arst_n(arst_n), .start(start_div),
		.a(cos_val), .b(v_val), .done(), .p(vc_prod)
	);

	dd_odom_smul #(.AW(CRW), .BW(V_W), .PW(VC_W), .B_SIGNED(1'b1)) u_mul_vs (
		.clk(clk), .arst_n(arst_n), .start(start_div),
		.a(sin_val), .b(v_val), .done(), .p(vs_prod)
	);

	dd_odom_smul #(.AW(VCS_W), .BW(TW), .PW(DX_W), .B_SIGNED(1'b0)) u_mul_dx (
		.clk(clk), .arst_n(arst_n), .start(start_step),
		.a($signed(vc_prod[CRW-2+VCS_W-1:CRW-2])), .b(dt_q), .done(), .p(dx_prod)
	);

	dd_odom_smul #(.AW(VCS_W), .BW(TW), .PW(DX_W), .B_SIGNED(1'b0)) u_mul_dy (
		.clk(clk), .arst_n(arst_n), .start(start_step),
		.a($signed(vs_prod[CRW-2+VCS_W-1:CRW-2])), .b(dt_q), .done(), .p(dy_prod)
	);

	// heading step
	dd_odom_smul #(.AW(YW), .BW(TW), .PW(YD_W), .B_SIGNED(1'b0)) u_mul_yd (
		.clk(clk), .arst_n(arst_n), .start(start_step),
		.a(yaw_val), .b(dt_q), .done(yd_done), .p(yd_prod)
	);

	dd_odom_smul #(
		.AW(YW), .BW(dd_odom_pkg::RAD_TO_BAM_W), .PW(YD_W), .B_SIGNED(1'b0)
	) u_mul_bam (
		.clk(clk), .arst_n(arst_n), .start(start_turn),
		.a($signed(yd_prod[TW+YW-1:TW])), .b(dd_odom_pkg::RAD_TO_BAM),
		.done(bam_done), .p(bam_prod)
	);

	assign bam = bam_prod[YD_W-1:YD_W-HW];

	// pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q       <= '0;
			pose_y_q       <= '0;
			pose_heading_q <= '0;
		end else begin
			if (pose_we) begin
				pose_x_q <= sat_add(pose_x_q, $signed(dx_prod[TW+VCS_W-1:TW]));
				pose_y_q <= sat_add(pose_y_q, $signed(dy_prod[TW+VCS_W-1:TW]));
			end
			if (head_we) begin
				pose_heading_q <= pose_heading_q + bam;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_x_q       <= pose_x_q;
			out_y_q       <= pose_y_q;
			out_heading_q <= pose_heading_q;
			out_speed_q   <= YW'(v_val);
			out_yaw_q     <= yaw_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.position_x    = out_x_q;
	assign rsp.position_y    = out_y_q;
	assign rsp.heading_angle = out_heading_q;
	assign rsp.linear_speed  = out_speed_q;
	assign rsp.yaw_rate      = out_yaw_q;

endmodule
